### src/hermite_spline_eval_macros.svh
// assertion macros for the spline evaluator
`ifndef HERMITE_SPLINE_EVAL_MACROS_SVH
`define HERMITE_SPLINE_EVAL_MACROS_SVH
`ifndef SYNTHESIS
`define HSE_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define HSE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define HSE_ASSERT(label, cond, msg)
`define HSE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### src/hse_pkg.sv
`timescale 1ns / 1ps
package hse_pkg;
	localparam int TableDepth = 256;
	localparam int FracBits = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam logic [31:0] One = 32'(1) << FracBits;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MAX_X = 3'd1,
		REG_STEP = 3'd2,
		REG_INV_STEP = 3'd3,
		REG_NODE_COUNT = 3'd4
	} reg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [IdxW-1:0] seg;
		logic [FracBits-1:0] frac;
		logic clamp;
		logic lin;
	} job_t;

	typedef struct packed {
		logic [31:0] min_x;
		logic [31:0] max_x;
		logic [30:0] step;
		logic [30:0] inv_step;
		logic [7:0] node_count;
	} cfg_t;
endpackage

### src/hermite_spline_eval.sv
`timescale 1ns / 1ps
// uniform-grid cubic hermite spline evaluator, Q16.16
// in channel: valid/ready beat with command, node_index, node_value, node_slope,
//   query_x, linear_mode. command 0 writes node value and slope into the
//   table and yields no result; command 1 evaluates at query_x.
// out channel: valid/ready beat carrying result_value (saturated).
// config: apb-style port, registers min_x, max_x, step, inv_step,
//   node_count at byte addresses 0,4,8,12,16; write only while idle.
// throughput: one beat per cycle when the receiver keeps ready high.
// an input beat reaches result valid through 2 front stages, the
//   queue, 5 back stages and the output register; the multiplier chain of
//   the hermite basis sets the back depth.
// a write is visible to any evaluation accepted after it.
// reset clears all control state and loads register defaults; the node
//   table holds nothing defined until written.
// when the receiver stalls the back part freezes, the queue fills,
//   then the front part and finally in ready drop.
module hermite_spline_eval (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic command,
	input logic [7:0] node_index,
	input logic [31:0] node_value,
	input logic [31:0] node_slope,
	input logic [31:0] query_x,
	input logic linear_mode,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] result_value,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IW = hse_pkg::IdxW;
	localparam int QW = 65 + IW + $bits(hse_pkg::job_t);
	hse_pkg::cfg_t cfg_q;
	hse_pkg::reg_idx_t ridx;
	logic fj_valid, fj_ready, fj_wr, bj_valid, bj_ready;
	logic [IW-1:0] fj_widx;
	logic [31:0] fj_wval, fj_wslp;
	hse_pkg::job_t fj_job;
	logic [QW-1:0] qin, qout;

	assign pready = 1'b1;
	assign ridx = hse_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x <= 32'd0;
			cfg_q.max_x <= 32'h01000000;
			cfg_q.step <= 31'h10000;
			cfg_q.inv_step <= 31'h10000;
			cfg_q.node_count <= 8'd255;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				hse_pkg::REG_MIN_X: cfg_q.min_x <= pwdata;
				hse_pkg::REG_MAX_X: cfg_q.max_x <= pwdata;
				hse_pkg::REG_STEP: cfg_q.step <= pwdata[30:0];
				hse_pkg::REG_INV_STEP: cfg_q.inv_step <= pwdata[30:0];
				hse_pkg::REG_NODE_COUNT: cfg_q.node_count <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			hse_pkg::REG_MIN_X: prdata = cfg_q.min_x;
			hse_pkg::REG_MAX_X: prdata = cfg_q.max_x;
			hse_pkg::REG_STEP: prdata = {1'b0, cfg_q.step};
			hse_pkg::REG_INV_STEP: prdata = {1'b0, cfg_q.inv_step};
			hse_pkg::REG_NODE_COUNT: prdata = {24'd0, cfg_q.node_count};
			default: prdata = 32'd0;
		endcase
	end

	hse_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.valid(valid), .ready(ready), .command(command),
		.node_index(node_index), .node_value(node_value), .node_slope(node_slope),
		.query_x(query_x), .linear_mode(linear_mode),
		.job_valid(fj_valid), .job_ready(fj_ready), .job_wr(fj_wr),
		.job_widx(fj_widx), .job_wval(fj_wval), .job_wslp(fj_wslp), .job(fj_job)
	);

	assign qin = {fj_wr, fj_widx, fj_wval, fj_wslp, fj_job};

	hse_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fj_valid), .in_ready(fj_ready), .in_data(qin),
		.out_valid(bj_valid), .out_ready(bj_ready), .out_data(qout)
	);

	hse_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.job_valid(bj_valid), .job_ready(bj_ready),
		.job_wr(qout[QW-1]),
		.job_widx(qout[QW-2 -: IW]),
		.job_wval(qout[QW-2-IW -: 32]),
		.job_wslp(qout[QW-34-IW -: 32]),
		.job(hse_pkg::job_t'(qout[$bits(hse_pkg::job_t)-1:0])),
		.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value)
	);
endmodule

### src/hse_front.sv
`timescale 1ns / 1ps
// classify: clamp, cell index and fraction; writes pass to the back part
module hse_front (
	input logic clk,
	input logic arst_n,
	input hse_pkg::cfg_t cfg,
	input logic valid,
	output logic ready,
	input logic command,
	input logic [7:0] node_index,
	input logic [31:0] node_value,
	input logic [31:0] node_slope,
	input logic [31:0] query_x,
	input logic linear_mode,
	output logic job_valid,
	input logic job_ready,
	output logic job_wr,
	output logic [hse_pkg::IdxW-1:0] job_widx,
	output logic [31:0] job_wval,
	output logic [31:0] job_wslp,
	output hse_pkg::job_t job
);
	logic v_s1, v_s2;
	logic wr_s1, wr_s2;
	logic [hse_pkg::IdxW-1:0] widx_s1, widx_s2;
	logic [31:0] wval_s1, wslp_s1, wval_s2, wslp_s2;
	logic lin_s1, lin_s2;
	logic below_s1, above_s1;
	logic [31:0] d_s1;
	logic [63:0] p_s2;
	logic below_s2, above_s2;
	logic adv1, adv2;
	logic [63:0] cell_full;
	logic [7:0] n_idx;

	assign adv2 = !v_s2 || job_ready;
	assign adv1 = !v_s1 || adv2;
	assign ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid) begin
			wr_s1 <= (command == hse_pkg::CMD_WRITE);
			widx_s1 <= hse_pkg::IdxW'(node_index);
			wval_s1 <= node_value;
			wslp_s1 <= node_slope;
			lin_s1 <= linear_mode;
			below_s1 <= $signed(query_x) <= $signed(cfg.min_x);
			above_s1 <= $signed(query_x) >= $signed(cfg.max_x);
			// only used above min_x, where the distance fits 32 bits unsigned
			d_s1 <= query_x - cfg.min_x;
		end
		if (adv2 && v_s1) begin
			wr_s2 <= wr_s1;
			widx_s2 <= widx_s1;
			wval_s2 <= wval_s1;
			wslp_s2 <= wslp_s1;
			lin_s2 <= lin_s1;
			below_s2 <= below_s1;
			above_s2 <= above_s1;
			p_s2 <= 64'(d_s1) * 64'(cfg.inv_step);
		end
	end

	assign cell_full = p_s2 >> (2 * hse_pkg::FracBits);
	assign n_idx = cfg.node_count;

	always_comb begin
		job.lin = lin_s2;
		job.frac = p_s2[hse_pkg::FracBits +: hse_pkg::FracBits];
		job.clamp = 1'b0;
		job.seg = cell_full[hse_pkg::IdxW-1:0];
		if (below_s2) begin
			job.clamp = 1'b1;
			job.seg = '0;
		end else if (above_s2 || cell_full >= 64'(n_idx)) begin
			job.clamp = 1'b1;
			job.seg = hse_pkg::IdxW'(n_idx);
		end
	end

	assign job_valid = v_s2;
	assign job_wr = wr_s2;
	assign job_widx = widx_s2;
	assign job_wval = wval_s2;
	assign job_wslp = wslp_s2;
endmodule

### src/hse_queue.sv
`timescale 1ns / 1ps
`include "hermite_spline_eval_macros.svh"
// two-entry queue between front and back
module hse_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [64+hse_pkg::IdxW+$bits(hse_pkg::job_t):0] in_data,
	output logic out_valid,
	input logic out_ready,
	output logic [64+hse_pkg::IdxW+$bits(hse_pkg::job_t):0] out_data
);
	localparam int W = 65 + hse_pkg::IdxW + $bits(hse_pkg::job_t);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
		end
	end

	`HSE_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
	`HSE_ASSERT_NEXT(a_full_ptr, cnt_q == 2'd2, wp_q == rp_q || cnt_q != 2'd2, "full ptr")
	`HSE_ASSERT_NEXT(a_pop_cnt, pop && !push, cnt_q == 2'($past(cnt_q) - 2'd1), "pop count")
endmodule

### src/hse_back.sv
`timescale 1ns / 1ps
`include "hermite_spline_eval_macros.svh"
// table, basis weights and blend; stalls only through the output stage
module hse_back (
	input logic clk,
	input logic arst_n,
	input hse_pkg::cfg_t cfg,
	input logic job_valid,
	output logic job_ready,
	input logic job_wr,
	input logic [hse_pkg::IdxW-1:0] job_widx,
	input logic [31:0] job_wval,
	input logic [31:0] job_wslp,
	input hse_pkg::job_t job,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] result_value
);
	localparam int FB = hse_pkg::FracBits;
	logic [31:0] vtab [hse_pkg::TableDepth];
	logic [31:0] stab [hse_pkg::TableDepth];
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv;
	logic ev;
	logic [hse_pkg::IdxW-1:0] c1;
	// s1: table reads, weights of first level
	logic [31:0] v0_s1, v1_s1, s0_s1, s1_s1;
	logic [FB:0] f_s1, g_s1;
	logic lin_s1, clamp_s1;
	// s2
	logic [FB:0] gg_s2, ff_s2, f_s2, g_s2;
	logic [31:0] v0_s2, v1_s2, s0_s2, s1_s2;
	logic lin_s2, clamp_s2;
	// s3: basis
	logic [FB+1:0] h00_s3, h10_s3, h01_s3, m11_s3;
	logic [31:0] v0_s3, v1_s3, s0_s3, s1_s3;
	logic [FB:0] f_s3, g_s3;
	logic lin_s3, clamp_s3;
	// s4: products
	logic signed [63:0] a0_s4, a1_s4, b0_s4, b1_s4;
	logic [31:0] v0_s4;
	logic lin_s4, clamp_s4;
	// s5
	logic signed [63:0] a_s5;
	logic signed [31:0] sl_s5;
	logic [31:0] v0_s5;
	logic lin_s5, clamp_s5;
	// s6 output register
	logic ov_q;
	logic [31:0] res_q;
	logic signed [63:0] t6, sum6;
	logic [2*FB+3:0] h00w, h10w, h01w, m11w;
	logic [2*FB+1:0] ggw, ffw;

	assign adv = !ov_q || out_ready;
	assign job_ready = adv;
	assign ev = job_valid && adv && !job_wr;
	assign c1 = job.seg + 1'b1;

	always_ff @(posedge clk) begin
		if (job_valid && adv && job_wr) begin
			vtab[job_widx] <= job_wval;
			stab[job_widx] <= job_wslp;
		end
		if (ev) begin
			v0_s1 <= vtab[job.seg];
			v1_s1 <= vtab[c1];
			s0_s1 <= stab[job.seg];
			s1_s1 <= stab[c1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= ev;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			ov_q <= v_s5;
		end
	end

	assign ggw = g_s1 * g_s1;
	assign ffw = f_s1 * f_s1;
	assign h00w = (2*FB+4)'((FB+2)'(hse_pkg::One) + (FB+2)'({f_s2, 1'b0})) * gg_s2;
	assign h10w = (2*FB+4)'(f_s2) * gg_s2;
	assign h01w = (2*FB+4)'(ff_s2) * (2*FB+4)'((FB+2)'(3 * hse_pkg::One) - (FB+2)'({f_s2, 1'b0}));
	assign m11w = (2*FB+4)'(ff_s2) * g_s2;
	// slope term stays within 32 bits since h10 + m11 never exceeds a quarter
	assign t6 = 64'(sl_s5 * $signed({1'b0, cfg.step}));
	assign sum6 = lin_s5 ? a_s5 >>> FB : (a_s5 >>> FB) + (t6 >>> FB);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ev) begin
				f_s1 <= (FB+1)'(job.frac);
				g_s1 <= (FB+1)'(hse_pkg::One) - (FB+1)'(job.frac);
				lin_s1 <= job.lin;
				clamp_s1 <= job.clamp;
			end
			gg_s2 <= (FB+1)'(ggw >> FB); ff_s2 <= (FB+1)'(ffw >> FB);
			f_s2 <= f_s1; g_s2 <= g_s1;
			v0_s2 <= v0_s1; v1_s2 <= v1_s1; s0_s2 <= s0_s1; s1_s2 <= s1_s1;
			lin_s2 <= lin_s1; clamp_s2 <= clamp_s1;
			h00_s3 <= (FB+2)'(h00w >> FB); h10_s3 <= (FB+2)'(h10w >> FB);
			h01_s3 <= (FB+2)'(h01w >> FB); m11_s3 <= (FB+2)'(m11w >> FB);
			f_s3 <= f_s2; g_s3 <= g_s2;
			v0_s3 <= v0_s2; v1_s3 <= v1_s2; s0_s3 <= s0_s2; s1_s3 <= s1_s2;
			lin_s3 <= lin_s2; clamp_s3 <= clamp_s2;
			if (lin_s3) begin
				a0_s4 <= 64'($signed(v0_s3) * $signed({1'b0, g_s3}));
				a1_s4 <= 64'($signed(v1_s3) * $signed({1'b0, f_s3}));
				b0_s4 <= '0; b1_s4 <= '0;
			end else begin
				a0_s4 <= 64'($signed(v0_s3) * $signed({1'b0, h00_s3}));
				a1_s4 <= 64'($signed(v1_s3) * $signed({1'b0, h01_s3}));
				b0_s4 <= 64'($signed(s0_s3) * $signed({1'b0, h10_s3}));
				b1_s4 <= 64'($signed(s1_s3) * $signed({1'b0, m11_s3}));
			end
			v0_s4 <= v0_s3; lin_s4 <= lin_s3; clamp_s4 <= clamp_s3;
			a_s5 <= a0_s4 + a1_s4;
			sl_s5 <= 32'((b0_s4 - b1_s4) >>> FB);
			v0_s5 <= v0_s4; lin_s5 <= lin_s4; clamp_s5 <= clamp_s4;
			if (clamp_s5) res_q <= v0_s5;
			else if (sum6 > 64'sd2147483647) res_q <= 32'h7fffffff;
			else if (sum6 < -64'sd2147483648) res_q <= 32'h80000000;
			else res_q <= sum6[31:0];
		end
	end

	assign out_valid = ov_q;
	assign result_value = res_q;

	`HSE_ASSERT_NEXT(a_hold, ov_q && !out_ready, ov_q && $stable(res_q), "result dropped")
	`HSE_ASSERT_NEXT(a_flow, adv && v_s5, ov_q, "pipeline lost a result")
	`HSE_ASSERT(a_ready, job_ready == (!ov_q || out_ready), "back ready mismatch")
endmodule
